[hdl/mahf_pkg.sv]
// shared types, constants and header tables of the mpeg audio header finder
package mahf_pkg;

   // header field codes
   localparam logic [11:0] SyncPattern   = 12'hFFE;
   localparam logic [3:0]  BadBitrateIdx = 4'hF;
   localparam logic [1:0]  BadRateIdx    = 2'h3;
   localparam logic [1:0]  EmphReserved  = 2'd2;

   // raw version bits of the header
   localparam logic [1:0] VerBitsMpeg1  = 2'd3;
   localparam logic [1:0] VerBitsMpeg2  = 2'd2;
   localparam logic [1:0] VerBitsMpeg25 = 2'd0;

   // decoded version codes
   localparam logic [1:0] VerMpeg1  = 2'd0;
   localparam logic [1:0] VerMpeg2  = 2'd1;
   localparam logic [1:0] VerMpeg25 = 2'd2;

   // decoded layer codes
   localparam logic [1:0] LayerNone  = 2'd0;
   localparam logic [1:0] LayerOne   = 2'd1;
   localparam logic [1:0] LayerThree = 2'd3;

   // frame length coefficients
   localparam logic [17:0] CoefLayerOne   = 18'd12000;
   localparam logic [17:0] CoefFull       = 18'd144000;
   localparam logic [17:0] CoefLsfLayer3  = 18'd72000;

   // bit-serial divider geometry
   localparam int DivSteps    = 26;
   localparam int DivCntWidth = $clog2(DivSteps);

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_DONE
   } mahf_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic load_prod;
      logic div_step;
      logic load_out;
   } mahf_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic hit;
      logic free_format;
      logic div_last;
      logic out_busy;
   } mahf_status_type;

   // bitrate in kbps, rows by [lsf][layer], layer row 0 unused
   localparam logic [8:0] KbpsTab [2][4][16] = '{
      '{
         '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
           9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
         '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
         '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
      },
      '{
         '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
           9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
      }
   };

   // sample rate in hz, rows by decoded version, last row unused
   localparam logic [15:0] RateTab [4][4] = '{
      '{16'd44100, 16'd48000, 16'd32000, 16'd0},
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd11025, 16'd12000, 16'd8000,  16'd0},
      '{16'd0,     16'd0,     16'd0,     16'd0}
   };

   // coefficient of the frame length formula
   function automatic logic [17:0] frame_coef(input logic [1:0] layer,
                                               input logic [1:0] version);
      logic [17:0] coef;
      if (layer == LayerOne) begin
         coef = CoefLayerOne;
      end else if (layer == LayerThree && version != VerMpeg1) begin
         coef = CoefLsfLayer3;
      end else begin
         coef = CoefFull;
      end
      return coef;
   endfunction

endpackage

[hdl/mpeg_audio_header_finder.sv]
// top level of the mpeg audio header finder
// Scans an audio byte stream, one byte per req beat, and tests each four-byte
// window (three held bytes plus the new one) as a frame header; each valid
// header gives one rsp beat with the decoded fields and frame length. A byte
// that completes no header leaves req open, and the next byte may come in the
// following cycle. A free-format header holds req off until the result register
// loads; a header with a table bitrate holds it off through the product load,
// the 26-step bit-serial divider that forms the frame length and the result
// load. Either wait grows while the result register waits on rsp_stall.
// req_stream_start clears the window before its byte is taken.
module mpeg_audio_header_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_version,
   output logic [1:0]  rsp_layer,
   output logic [8:0]  rsp_bitrate_kbps,
   output logic [15:0] rsp_sample_rate_hz,
   output logic        rsp_padding,
   output logic [1:0]  rsp_channel_mode,
   output logic [1:0]  rsp_mode_extension,
   output logic        rsp_copyright_bit,
   output logic        rsp_original_bit,
   output logic [1:0]  rsp_emphasis,
   output logic        rsp_crc_protected,
   output logic [11:0] rsp_frame_length_bytes
);

   mahf_pkg::mahf_cmd_type    cmd;
   mahf_pkg::mahf_status_type status;

   // controller
   mahf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   mahf_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_data_byte          (req_data_byte),
      .req_stream_start       (req_stream_start),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_version            (rsp_version),
      .rsp_layer              (rsp_layer),
      .rsp_bitrate_kbps       (rsp_bitrate_kbps),
      .rsp_sample_rate_hz     (rsp_sample_rate_hz),
      .rsp_padding            (rsp_padding),
      .rsp_channel_mode       (rsp_channel_mode),
      .rsp_mode_extension     (rsp_mode_extension),
      .rsp_copyright_bit      (rsp_copyright_bit),
      .rsp_original_bit       (rsp_original_bit),
      .rsp_emphasis           (rsp_emphasis),
      .rsp_crc_protected      (rsp_crc_protected),
      .rsp_frame_length_bytes (rsp_frame_length_bytes)
   );

endmodule

[hdl/mahf_ctrl.sv]
// controller state machine of the mpeg audio header finder
module mahf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mahf_pkg::mahf_status_type  status,
   output mahf_pkg::mahf_cmd_type     cmd
);

   mahf_pkg::mahf_state_type state_ff;
   mahf_pkg::mahf_state_type state_in;

   logic accept;

   assign req_stall = (state_ff != mahf_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mahf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mahf_pkg::ST_IDLE: begin
            if (accept && status.hit) begin
               state_in = status.free_format ? mahf_pkg::ST_DONE : mahf_pkg::ST_MULT;
            end
         end
         mahf_pkg::ST_MULT: begin
            state_in = mahf_pkg::ST_DIV;
         end
         mahf_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = mahf_pkg::ST_DONE;
            end
         end
         mahf_pkg::ST_DONE: begin
            if (!status.out_busy) begin
               state_in = mahf_pkg::ST_IDLE;
            end
         end
         default: state_in = mahf_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         mahf_pkg::ST_IDLE: cmd.accept    = accept;
         mahf_pkg::ST_MULT: cmd.load_prod = 1'b1;
         mahf_pkg::ST_DIV:  cmd.div_step  = 1'b1;
         mahf_pkg::ST_DONE: cmd.load_out  = !status.out_busy;
         default:           cmd = '0;
      endcase
   end

endmodule

[hdl/mahf_datapath.sv]
// byte window, header decode, frame length divider and result register
module mahf_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_stream_start,
   input  mahf_pkg::mahf_cmd_type     cmd,
   output mahf_pkg::mahf_status_type  status,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_version,
   output logic [1:0]                 rsp_layer,
   output logic [8:0]                 rsp_bitrate_kbps,
   output logic [15:0]                rsp_sample_rate_hz,
   output logic                       rsp_padding,
   output logic [1:0]                 rsp_channel_mode,
   output logic [1:0]                 rsp_mode_extension,
   output logic                       rsp_copyright_bit,
   output logic                       rsp_original_bit,
   output logic [1:0]                 rsp_emphasis,
   output logic                       rsp_crc_protected,
   output logic [11:0]                rsp_frame_length_bytes
);

   localparam int DivW = mahf_pkg::DivSteps;
   localparam int CntW = mahf_pkg::DivCntWidth;

   // window state
   logic [23:0] window_ff, window_in;
   logic [1:0]  held_ff, held_in;

   // decode signals
   logic [23:0] win_eff;
   logic [1:0]  held_eff;
   logic [7:0]  b0, b1, b2, b3;
   logic [11:0] sync_bits;
   logic [1:0]  ver_bits, lay_bits, ver_dec, lay_dec;
   logic        ver_ok;
   logic [3:0]  br_idx;
   logic [1:0]  sr_idx;
   logic [8:0]  br_dec;
   logic [15:0] sr_dec;

   // captured header
   logic [1:0]  ver_ff, lay_ff, mode_ff, modex_ff, emph_ff;
   logic [8:0]  br_ff;
   logic [15:0] sr_ff;
   logic        pad_ff, copy_ff, orig_ff, crc_ff;

   // divider
   logic [DivW-1:0] quo_ff, quo_in;
   logic [16:0]     rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [26:0]     prod;
   logic [16:0]     rem_shift;
   logic [17:0]     diff;
   logic [11:0]     q_plus, len;

   // output register
   logic        out_valid_ff;
   logic [11:0] len_ff;

   // effective window after a stream start
   assign win_eff  = req_stream_start ? 24'd0 : window_ff;
   assign held_eff = req_stream_start ? 2'd0 : held_ff;
   assign b0 = win_eff[23:16];
   assign b1 = win_eff[15:8];
   assign b2 = win_eff[7:0];
   assign b3 = req_data_byte;

   // header field decode
   assign sync_bits = {b0, b1[7:5], 1'b0};
   assign ver_bits  = b1[4:3];
   assign lay_bits  = b1[2:1];
   assign br_idx    = b2[7:4];
   assign sr_idx    = b2[3:2];

   always_comb begin
      ver_ok  = 1'b1;
      ver_dec = mahf_pkg::VerMpeg1;
      unique case (ver_bits)
         mahf_pkg::VerBitsMpeg1:  ver_dec = mahf_pkg::VerMpeg1;
         mahf_pkg::VerBitsMpeg2:  ver_dec = mahf_pkg::VerMpeg2;
         mahf_pkg::VerBitsMpeg25: ver_dec = mahf_pkg::VerMpeg25;
         default:                 ver_ok  = 1'b0;
      endcase
   end

   assign lay_dec = 2'(3'd4 - {1'b0, lay_bits});
   assign br_dec  = mahf_pkg::KbpsTab[ver_dec != mahf_pkg::VerMpeg1][lay_dec][br_idx];
   assign sr_dec  = mahf_pkg::RateTab[ver_dec][sr_idx];

   assign status.hit = (held_eff == 2'd3) && (sync_bits == mahf_pkg::SyncPattern)
                       && ver_ok && (lay_dec != mahf_pkg::LayerNone)
                       && (br_idx != mahf_pkg::BadBitrateIdx)
                       && (sr_idx != mahf_pkg::BadRateIdx)
                       && (b3[1:0] != mahf_pkg::EmphReserved);
   assign status.free_format = (br_idx == 4'd0);

   // window shift on each accepted beat
   always_comb begin
      window_in = window_ff;
      held_in   = held_ff;
      if (cmd.accept) begin
         window_in = {win_eff[15:0], req_data_byte};
         held_in   = (held_eff == 2'd3) ? 2'd3 : held_eff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         held_ff   <= '0;
      end else begin
         window_ff <= window_in;
         held_ff   <= held_in;
      end
   end

   // header capture on accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ver_ff   <= ver_dec;
         lay_ff   <= lay_dec;
         br_ff    <= br_dec;
         sr_ff    <= sr_dec;
         pad_ff   <= b2[1];
         mode_ff  <= b3[7:6];
         modex_ff <= b3[5:4];
         copy_ff  <= b3[3];
         orig_ff  <= b3[2];
         emph_ff  <= b3[1:0];
         crc_ff   <= !b1[0];
      end
   end

   // coefficient times bitrate
   assign prod = 27'(mahf_pkg::frame_coef(lay_ff, ver_ff)) * 27'(br_ff);

   // restoring divide step, one quotient bit a cycle
   assign rem_shift = {rem_ff[15:0], quo_ff[DivW-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, sr_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.load_prod) begin
         quo_in = prod[DivW-1:0];
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[DivW-2:0], !diff[17]};
         rem_in = diff[17] ? rem_shift : diff[16:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign status.div_last = (cnt_ff == CntW'(DivW - 1));

   // frame length from the quotient
   assign q_plus = quo_ff[11:0] + {11'd0, pad_ff};
   always_comb begin
      if (br_ff == 9'd0) begin
         len = '0;
      end else if (lay_ff == mahf_pkg::LayerOne) begin
         len = {q_plus[9:0], 2'b00};
      end else begin
         len = q_plus;
      end
   end

   // result register
   assign status.out_busy = out_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         len_ff <= len;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_frame_length_bytes = len_ff;

   // result fields held until the next load
   logic [1:0]  o_ver_ff, o_lay_ff, o_mode_ff, o_modex_ff, o_emph_ff;
   logic [8:0]  o_br_ff;
   logic [15:0] o_sr_ff;
   logic        o_pad_ff, o_copy_ff, o_orig_ff, o_crc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_ver_ff   <= ver_ff;
         o_lay_ff   <= lay_ff;
         o_br_ff    <= br_ff;
         o_sr_ff    <= sr_ff;
         o_pad_ff   <= pad_ff;
         o_mode_ff  <= mode_ff;
         o_modex_ff <= modex_ff;
         o_copy_ff  <= copy_ff;
         o_orig_ff  <= orig_ff;
         o_emph_ff  <= emph_ff;
         o_crc_ff   <= crc_ff;
      end
   end

   assign rsp_version        = o_ver_ff;
   assign rsp_layer          = o_lay_ff;
   assign rsp_bitrate_kbps   = o_br_ff;
   assign rsp_sample_rate_hz = o_sr_ff;
   assign rsp_padding        = o_pad_ff;
   assign rsp_channel_mode   = o_mode_ff;
   assign rsp_mode_extension = o_modex_ff;
   assign rsp_copyright_bit  = o_copy_ff;
   assign rsp_original_bit   = o_orig_ff;
   assign rsp_emphasis       = o_emph_ff;
   assign rsp_crc_protected  = o_crc_ff;

endmodule

[hdl/mahf_checker.sv]
// port-level checker of the mpeg audio header finder and its bind
module mahf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_version,
   input logic [1:0]  rsp_layer,
   input logic [8:0]  rsp_bitrate_kbps,
   input logic [1:0]  rsp_emphasis,
   input logic [11:0] rsp_frame_length_bytes
);

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result beat keeps its frame length and bitrate
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_frame_length_bytes)
                                 && $stable(rsp_bitrate_kbps))
      else $error("rsp payload changed while stalled");

   // reported headers never carry reserved codes
   a_no_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_emphasis != 2'd2 && rsp_version != 2'd3
                    && rsp_layer != 2'd0)
      else $error("reserved header code reported");

   // frame length is zero exactly for free format
   a_free_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bitrate_kbps == 9'd0) == (rsp_frame_length_bytes == 12'd0))
      else $error("frame length does not match free format");

   // layer one frames are whole slots of four bytes
   a_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_layer == 2'd1 |-> rsp_frame_length_bytes[1:0] == 2'b00)
      else $error("layer one frame length not a multiple of four");

endmodule

bind mpeg_audio_header_finder mahf_checker u_mahf_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_version            (rsp_version),
   .rsp_layer              (rsp_layer),
   .rsp_bitrate_kbps       (rsp_bitrate_kbps),
   .rsp_emphasis           (rsp_emphasis),
   .rsp_frame_length_bytes (rsp_frame_length_bytes)
);

[verif/tb_mpeg_audio_header_finder.sv]
// testbench of the mpeg audio header finder: byte stream stimulus, header prediction and checks
module tb_mpeg_audio_header_finder;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HalfPeriod  = 4;
   localparam int ItemTarget  = 1950;
   localparam int CycleLimit  = 800000;
   localparam int TailCycles  = 40;
   localparam int HoldCycles  = 400;
   localparam int ReportLimit = 10;

   // raw header codes that the package leaves unnamed
   localparam logic [1:0] VerBitsReserved   = 2'd1;
   localparam logic [1:0] LayerBitsReserved = 2'd0;
   localparam logic [1:0] EmphFull          = 2'd3;

   // bitrate in kbps by [lsf][layer - 1][index]
   localparam int unsigned KbpsRows [2][3][15] = '{
      '{
         '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
         '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320}
      },
      '{
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160},
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
      }
   };

   // sample rate in hz by [decoded version][index]
   localparam int unsigned RateRows [3][3] = '{
      '{44100, 48000, 32000},
      '{22050, 24000, 16000},
      '{11025, 12000, 8000}
   };

   typedef struct packed {
      logic [1:0]  version;
      logic [1:0]  layer;
      logic [8:0]  bitrate_kbps;
      logic [15:0] sample_rate_hz;
      logic        padding;
      logic [1:0]  channel_mode;
      logic [1:0]  mode_extension;
      logic        copyright_bit;
      logic        original_bit;
      logic [1:0]  emphasis;
      logic        crc_protected;
      logic [11:0] frame_length_bytes;
   } frame_header_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_stream_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_version;
   logic [1:0]  rsp_layer;
   logic [8:0]  rsp_bitrate_kbps;
   logic [15:0] rsp_sample_rate_hz;
   logic        rsp_padding;
   logic [1:0]  rsp_channel_mode;
   logic [1:0]  rsp_mode_extension;
   logic        rsp_copyright_bit;
   logic        rsp_original_bit;
   logic [1:0]  rsp_emphasis;
   logic        rsp_crc_protected;
   logic [11:0] rsp_frame_length_bytes;

   // predictor state and expected headers
   logic [23:0]      held_bytes = 24'd0;
   int               held_count = 0;
   frame_header_type header_q[$];

   int  error_count = 0;
   int  sent_count = 0;
   int  burst_left = 0;
   int  cycle_count = 0;
   bit  hold_request = 1'b0;

   mpeg_audio_header_finder u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_data_byte          (req_data_byte),
      .req_stream_start       (req_stream_start),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_version            (rsp_version),
      .rsp_layer              (rsp_layer),
      .rsp_bitrate_kbps       (rsp_bitrate_kbps),
      .rsp_sample_rate_hz     (rsp_sample_rate_hz),
      .rsp_padding            (rsp_padding),
      .rsp_channel_mode       (rsp_channel_mode),
      .rsp_mode_extension     (rsp_mode_extension),
      .rsp_copyright_bit      (rsp_copyright_bit),
      .rsp_original_bit       (rsp_original_bit),
      .rsp_emphasis           (rsp_emphasis),
      .rsp_crc_protected      (rsp_crc_protected),
      .rsp_frame_length_bytes (rsp_frame_length_bytes)
   );

   always #HalfPeriod clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // decode one four-byte window, returns 1 for a valid frame header
   function automatic logic decode_header(input logic [31:0] w,
                                          output frame_header_type hdr);
      logic [1:0]  ver_bits;
      logic [1:0]  lay_bits;
      logic [1:0]  sr_idx;
      logic [1:0]  emph;
      logic [3:0]  br_idx;
      logic        found;
      int unsigned layer_num;
      int unsigned kbps;
      int unsigned rate_hz;
      int unsigned len;
      hdr = '0;
      ver_bits = w[20:19];
      lay_bits = w[18:17];
      br_idx = w[15:12];
      sr_idx = w[11:10];
      emph = w[1:0];
      found = ({w[31:24], w[23:21], 1'b0} == mahf_pkg::SyncPattern)
         && ver_bits != VerBitsReserved
         && lay_bits != LayerBitsReserved && br_idx != mahf_pkg::BadBitrateIdx
         && sr_idx != mahf_pkg::BadRateIdx && emph != mahf_pkg::EmphReserved;
      if (found) begin
         case (ver_bits)
            mahf_pkg::VerBitsMpeg1: hdr.version = mahf_pkg::VerMpeg1;
            mahf_pkg::VerBitsMpeg2: hdr.version = mahf_pkg::VerMpeg2;
            default:                hdr.version = mahf_pkg::VerMpeg25;
         endcase
         layer_num = 4 - lay_bits;
         kbps = KbpsRows[(hdr.version == mahf_pkg::VerMpeg1) ? 0 : 1][layer_num - 1][br_idx];
         rate_hz = RateRows[hdr.version][sr_idx];
         // frame length, zero for free format
         if (kbps == 0) begin
            len = 0;
         end else if (layer_num == mahf_pkg::LayerOne) begin
            len = (mahf_pkg::CoefLayerOne * kbps / rate_hz + w[9]) * 4;
         end else if (layer_num == mahf_pkg::LayerThree
                      && hdr.version != mahf_pkg::VerMpeg1) begin
            len = mahf_pkg::CoefLsfLayer3 * kbps / rate_hz + w[9];
         end else begin
            len = mahf_pkg::CoefFull * kbps / rate_hz + w[9];
         end
         hdr.layer = layer_num[1:0];
         hdr.bitrate_kbps = kbps[8:0];
         hdr.sample_rate_hz = rate_hz[15:0];
         hdr.padding = w[9];
         hdr.channel_mode = w[7:6];
         hdr.mode_extension = w[5:4];
         hdr.copyright_bit = w[3];
         hdr.original_bit = w[2];
         hdr.emphasis = emph;
         hdr.crc_protected = ~w[16];
         hdr.frame_length_bytes = len[11:0];
      end
      return found;
   endfunction

   // advance the byte window by one accepted beat
   task automatic track_byte(input logic [7:0] b, input logic start);
      frame_header_type hdr;
      if (start) begin
         held_bytes = 24'd0;
         held_count = 0;
      end
      if (held_count >= 3 && decode_header({held_bytes, b}, hdr)) begin
         header_q.push_back(hdr);
      end
      held_bytes = {held_bytes[15:0], b};
      if (held_count < 3) begin
         held_count++;
      end
   endtask

   // one byte beat, with bursts and random gaps
   task automatic send_byte(input logic [7:0] b, input logic start);
      int  gap;
      bit  taken;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_stream_start <= start;
      // stall sampled at the falling edge ahead of the rising edge it applies to
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      track_byte(b, start);
      sent_count++;
      burst_left--;
   endtask

   task automatic send_word(input logic [31:0] w, input logic start);
      send_byte(w[31:24], start);
      send_byte(w[23:16], 1'b0);
      send_byte(w[15:8], 1'b0);
      send_byte(w[7:0], 1'b0);
   endtask

   // random header, clean or with one broken field
   function automatic logic [31:0] make_header(input bit clean);
      logic [7:0] b0;
      logic [2:0] sync_low;
      logic [1:0] ver_bits;
      logic [1:0] lay_bits;
      logic [3:0] br_idx;
      logic [1:0] sr_idx;
      logic [7:0] tail;
      logic [7:0] mid;
      b0 = 8'hFF;
      sync_low = 3'b111;
      case ($urandom_range(0, 2))
         0:       ver_bits = mahf_pkg::VerBitsMpeg1;
         1:       ver_bits = mahf_pkg::VerBitsMpeg2;
         default: ver_bits = mahf_pkg::VerBitsMpeg25;
      endcase
      lay_bits = 2'($urandom_range(1, 3));
      br_idx = 4'($urandom_range(0, 14));
      sr_idx = 2'($urandom_range(0, 2));
      mid = 8'($urandom);
      tail = 8'($urandom);
      if (tail[1:0] == mahf_pkg::EmphReserved) begin
         tail[1:0] = EmphFull;
      end
      if (!clean) begin
         case ($urandom_range(0, 6))
            0:       ver_bits = VerBitsReserved;
            1:       lay_bits = LayerBitsReserved;
            2:       br_idx = mahf_pkg::BadBitrateIdx;
            3:       sr_idx = mahf_pkg::BadRateIdx;
            4:       tail[1:0] = mahf_pkg::EmphReserved;
            5:       sync_low = 3'($urandom_range(0, 6));
            default: b0 = 8'($urandom_range(0, 254));
         endcase
      end
      return {b0, sync_low, ver_bits, lay_bits, mid[0], br_idx, sr_idx, mid[2:1], tail};
   endfunction

   // lower valid and let every expected header come out
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (header_q.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   // result stall pattern, with a long hold-off on request
   always @(posedge clock) begin : stall_gen
      static logic [15:0] stall_pattern = 16'h0;
      static int          pattern_age = 0;
      static int          hold_left = 0;
      if (hold_request && hold_left == 0) begin
         hold_left = HoldCycles;
         hold_request = 1'b0;
      end
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern = 16'h0;
            1:       stall_pattern = 16'($urandom);
            default: stall_pattern = 16'($urandom & $urandom);
         endcase
         pattern_age = $urandom_range(16, 96);
      end
      pattern_age--;
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= stall_pattern[0];
      end
   end

   function automatic string header_text(input frame_header_type h);
      return $sformatf({"ver=%0d lay=%0d kbps=%0d hz=%0d pad=%0d mode=%0d ext=%0d",
                        " cp=%0d org=%0d emph=%0d crc=%0d len=%0d"},
         h.version, h.layer, h.bitrate_kbps, h.sample_rate_hz, h.padding, h.channel_mode,
         h.mode_extension, h.copyright_bit, h.original_bit, h.emphasis, h.crc_protected,
         h.frame_length_bytes);
   endfunction

   // check each result beat against the oldest expected header
   always @(negedge clock) begin : header_check
      frame_header_type got;
      frame_header_type exp_hdr;
      string            bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_version, rsp_layer, rsp_bitrate_kbps, rsp_sample_rate_hz, rsp_padding,
                 rsp_channel_mode, rsp_mode_extension, rsp_copyright_bit, rsp_original_bit,
                 rsp_emphasis, rsp_crc_protected, rsp_frame_length_bytes};
         if (header_q.size() == 0) begin
            error_count++;
            if (error_count <= ReportLimit) begin
               $display("unexpected header beat: %s", header_text(got));
            end
         end else begin
            exp_hdr = header_q.pop_front();
            bad = "";
            if (got.version !== exp_hdr.version) bad = {bad, " version"};
            if (got.layer !== exp_hdr.layer) bad = {bad, " layer"};
            if (got.bitrate_kbps !== exp_hdr.bitrate_kbps) bad = {bad, " bitrate_kbps"};
            if (got.sample_rate_hz !== exp_hdr.sample_rate_hz) bad = {bad, " sample_rate_hz"};
            if (got.padding !== exp_hdr.padding) bad = {bad, " padding"};
            if (got.channel_mode !== exp_hdr.channel_mode) bad = {bad, " channel_mode"};
            if (got.mode_extension !== exp_hdr.mode_extension) bad = {bad, " mode_extension"};
            if (got.copyright_bit !== exp_hdr.copyright_bit) bad = {bad, " copyright_bit"};
            if (got.original_bit !== exp_hdr.original_bit) bad = {bad, " original_bit"};
            if (got.emphasis !== exp_hdr.emphasis) bad = {bad, " emphasis"};
            if (got.crc_protected !== exp_hdr.crc_protected) bad = {bad, " crc_protected"};
            if (got.frame_length_bytes !== exp_hdr.frame_length_bytes) begin
               bad = {bad, " frame_length_bytes"};
            end
            if (bad != "") begin
               error_count++;
               if (error_count <= ReportLimit) begin
                  $display("header mismatch in%s", bad);
                  $display("  expected %s", header_text(exp_hdr));
                  $display("  actual   %s", header_text(got));
               end
            end
         end
      end
   end

   // mpeg-1 layer iii header, the first three bytes give nothing
   task automatic test_short_window();
      send_word(32'hFFFB9064, 1'b1);
   endtask

   // free-format header whose last byte starts the next header
   task automatic test_overlap();
      send_word(32'hFFFB00FF, 1'b0);
      send_byte(8'hFB, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h44, 1'b0);
   endtask

   // mpeg-2.5 layer iii at index 1, crc on, all flags set
   task automatic test_mpeg25_rate();
      send_word(32'hFFE2963D, 1'b0);
   endtask

   // top bitrate layer i mpeg-1 and longest frame mpeg-2.5 layer ii
   task automatic test_extremes();
      send_word(32'hFFFFEAFF, 1'b0);
      send_word(32'hFFE4EA00, 1'b0);
   endtask

   // window cleared on the last byte of a header
   task automatic test_stream_start();
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFB, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h64, 1'b1);
   endtask

   // result side held off while headers keep coming
   task automatic test_result_backpressure();
      hold_request = 1'b1;
      repeat (10) send_word(make_header(1'b1), 1'b0);
      wait_for_results();
   endtask

   // mostly well-formed headers, some broken ones, noise and restarts
   task automatic test_random_stream();
      bit         restart;
      int         run;
      logic [7:0] b;
      restart = 1'b0;
      while (sent_count < ItemTarget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: send_word(make_header(1'b1), restart);
            6:                send_word(make_header(1'b0), restart);
            7: begin
               send_word(make_header(1'b1), restart);
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end
            default: begin
               run = $urandom_range(1, 8);
               repeat (run) begin
                  b = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                  send_byte(b, $urandom_range(0, 23) == 0);
               end
            end
         endcase
         restart = ($urandom_range(0, 15) == 0);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_short_window();
      test_overlap();
      test_mpeg25_rate();
      test_extremes();
      test_stream_start();
      test_result_backpressure();
      test_random_stream();
      wait_for_results();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
